### src/wsu_pkg.sv
// Shared types and constants for the frame unmasker.
// No dependencies; used by wsu_core and websocket_frame_unmasker.
package wsu_pkg;

  // Frame status codes reported on the last beat of a packet
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FINAL = 3'd1;
  localparam logic [2:0] ST_RESERVED  = 3'd2;
  localparam logic [2:0] ST_UNMASKED  = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // Length field encodings
  localparam logic [1:0] LEN_7  = 2'd0;
  localparam logic [1:0] LEN_16 = 2'd1;
  localparam logic [1:0] LEN_64 = 2'd2;

  // Header byte masks and escape values
  localparam logic [7:0] FIN_MASK  = 8'h80;
  localparam logic [7:0] RSV_MASK  = 8'h70;
  localparam logic [7:0] OPC_MASK  = 8'h0f;
  localparam logic [7:0] LEN_MASK  = 8'h7f;
  localparam logic [6:0] LEN_ESC16 = 7'd126;
  localparam logic [6:0] LEN_ESC64 = 7'd127;

  // Header byte index where the masking key starts, per length kind
  localparam logic [3:0] KEY_START_7  = 4'd2;
  localparam logic [3:0] KEY_START_16 = 4'd4;
  localparam logic [3:0] KEY_START_64 = 4'd10;
  localparam logic [3:0] HDR_IDX_MAX  = 4'd15;

  // One result as produced by the core for one input beat
  typedef struct packed {
    logic        emit;
    logic [7:0]  out_byte;
    logic        has_data;
    logic        end_of_frame;
    logic [2:0]  status;
    logic [3:0]  frame_opcode;
    logic [63:0] declared_length;
  } result_t;

endpackage

### src/wsu_core.sv
// Header parse, length/key capture and payload unmask state for one frame.
// Depends on wsu_pkg (result_t, status and header constants).
module wsu_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output wsu_pkg::result_t  res
);

  logic [3:0]  header_index, header_index_next;
  logic [1:0]  length_kind, length_kind_next;
  logic [63:0] length_accum, length_accum_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_phase, key_phase_next;
  logic        in_payload, in_payload_next;
  logic [2:0]  error_code, error_code_next;
  logic [3:0]  opcode_held, opcode_held_next;

  logic [3:0]  key_start;
  logic [7:0]  key_byte;
  logic        data;
  logic [7:0]  ob;
  logic [6:0]  len7;

  always_comb begin
    unique case (length_kind)
      wsu_pkg::LEN_16: key_start = wsu_pkg::KEY_START_16;
      wsu_pkg::LEN_64: key_start = wsu_pkg::KEY_START_64;
      default:         key_start = wsu_pkg::KEY_START_7;
    endcase
  end

  // key byte 0 sits in the top byte of the key register
  always_comb begin
    unique case (key_phase)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign len7 = in_byte[6:0] & wsu_pkg::LEN_MASK[6:0];

  always_comb begin
    header_index_next = header_index;
    length_kind_next  = length_kind;
    length_accum_next = length_accum;
    mask_key_next     = mask_key;
    key_phase_next    = key_phase;
    in_payload_next   = in_payload;
    error_code_next   = error_code;
    opcode_held_next  = opcode_held;
    data              = 1'b0;
    ob                = 8'h00;

    if (error_code == wsu_pkg::ST_OK) begin
      if (in_payload) begin
        ob             = in_byte ^ key_byte;
        data           = 1'b1;
        key_phase_next = key_phase + 2'd1;
      end else begin
        if (header_index == 4'd0) begin
          opcode_held_next = in_byte[3:0] & wsu_pkg::OPC_MASK[3:0];
          if ((in_byte & wsu_pkg::FIN_MASK) == 8'h00) begin
            error_code_next = wsu_pkg::ST_NOT_FINAL;
          end else if ((in_byte & wsu_pkg::RSV_MASK) != 8'h00) begin
            error_code_next = wsu_pkg::ST_RESERVED;
          end
        end else if (header_index == 4'd1) begin
          if ((in_byte & wsu_pkg::FIN_MASK) == 8'h00) begin
            error_code_next = wsu_pkg::ST_UNMASKED;
          end else if (len7 == wsu_pkg::LEN_ESC16) begin
            length_kind_next = wsu_pkg::LEN_16;
          end else if (len7 == wsu_pkg::LEN_ESC64) begin
            length_kind_next = wsu_pkg::LEN_64;
          end else begin
            length_kind_next  = wsu_pkg::LEN_7;
            length_accum_next = {57'd0, len7};
          end
        end else if (header_index < key_start) begin
          length_accum_next = {length_accum[55:0], in_byte};
        end else begin
          mask_key_next = {mask_key[23:0], in_byte};
          if (header_index == key_start + 4'd3) in_payload_next = 1'b1;
        end
        if (header_index != wsu_pkg::HDR_IDX_MAX) header_index_next = header_index + 4'd1;
      end
    end

    res.emit            = in_last | data;
    res.out_byte        = ob;
    res.has_data        = data;
    res.end_of_frame    = in_last;
    res.frame_opcode    = opcode_held_next;
    res.declared_length = length_accum_next;
    if (!in_last) begin
      res.status = wsu_pkg::ST_OK;
    end else if (error_code_next != wsu_pkg::ST_OK) begin
      res.status = error_code_next;
    end else if (!data) begin
      res.status = wsu_pkg::ST_TRUNCATED;
    end else begin
      res.status = wsu_pkg::ST_OK;
    end

    // packet end: back to the idle header state
    if (in_last) begin
      header_index_next = 4'd0;
      length_kind_next  = wsu_pkg::LEN_7;
      length_accum_next = 64'd0;
      mask_key_next     = 32'd0;
      key_phase_next    = 2'd0;
      in_payload_next   = 1'b0;
      error_code_next   = wsu_pkg::ST_OK;
      opcode_held_next  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index <= 4'd0;
      length_kind  <= wsu_pkg::LEN_7;
      length_accum <= 64'd0;
      mask_key     <= 32'd0;
      key_phase    <= 2'd0;
      in_payload   <= 1'b0;
      error_code   <= wsu_pkg::ST_OK;
      opcode_held  <= 4'd0;
    end else if (step) begin
      header_index <= header_index_next;
      length_kind  <= length_kind_next;
      length_accum <= length_accum_next;
      mask_key     <= mask_key_next;
      key_phase    <= key_phase_next;
      in_payload   <= in_payload_next;
      error_code   <= error_code_next;
      opcode_held  <= opcode_held_next;
    end
  end

endmodule

### src/websocket_frame_unmasker.sv
// Client frame deframer/unmasker, top level: input beat register, core, result register.
// Depends on wsu_pkg and wsu_core.
// Results are registered: input beat register, then core step, then result register onto m_*.
// Throughput: one input beat per cycle, sustained while m_tready keeps the result register draining.
// Header beats yield no output beat; each payload beat and each last beat yields one.
// Reset (rst, synchronous): empties both registers and returns the parser to header byte 0.
module websocket_frame_unmasker (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] out_byte, [10:8] status, [14:11] frame_opcode,
                                 // [78:15] declared_length, [79] zero pad
  output logic        m_tuser,   // has_data
  output logic        m_tlast    // end_of_frame
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic             out_free;   // result register can take a new beat this cycle
  logic             step;       // core consumes the registered input beat
  wsu_pkg::result_t res;

  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  // input side takes a beat whenever its register is empty or drains this cycle
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte_q <= s_tdata;
      in_last_q <= s_tlast;
    end
  end

  wsu_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (in_byte_q),
    .in_last (in_last_q),
    .res     (res)
  );

  // result register; header beats drop out here
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      m_tdata <= {1'b0, res.declared_length, res.frame_opcode, res.status, res.out_byte};
      m_tuser <= res.has_data;
      m_tlast <= res.end_of_frame;
    end
  end

endmodule

### verif/tb.sv
// Self-checking testbench for websocket_frame_unmasker: directed and random client frames.
// Depends on wsu_pkg and the unmasker RTL; holds its own frame parser model in a scoreboard.
module tb;

  localparam int ITEM_TARGET    = 1850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  // one expected output beat
  typedef struct packed {
    logic [7:0]  data;
    logic        has_data;
    logic        eof;
    logic [2:0]  status;
    logic [3:0]  opcode;
    logic [63:0] length;
  } unmask_beat_t;

  // ways a random frame gets broken
  typedef enum int {FLAW_NO_FIN, FLAW_RSV, FLAW_NO_MASK, FLAW_TRUNC, FLAW_NOISE} flaw_t;

  // Parser model plus queue of expected output beats
  class unmask_scoreboard;
    logic [3:0]  hdr_idx;
    logic [1:0]  len_kind;
    logic [63:0] len_acc;
    logic [31:0] mkey;
    logic [1:0]  phase;
    bit          payload_on;
    logic [2:0]  err;
    logic [3:0]  opc;
    unmask_beat_t expected_beats[$];
    int mismatches;
    int data_checked;
    int ends_by_status[5];

    function void clear_parser();
      hdr_idx = '0;
      len_kind = wsu_pkg::LEN_7;
      len_acc = '0;
      mkey = '0;
      phase = '0;
      payload_on = 0;
      err = wsu_pkg::ST_OK;
      opc = '0;
    endfunction

    function new();
      clear_parser();
      mismatches = 0;
      data_checked = 0;
      foreach (ends_by_status[i]) ends_by_status[i] = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // advance the parser by one accepted input beat
    function void take_rx_byte(logic [7:0] b, bit last);
      unmask_beat_t r;
      logic [3:0] ks;
      logic [7:0] ob;
      bit data;
      data = 0;
      ob = '0;
      if (err == wsu_pkg::ST_OK) begin
        if (payload_on) begin
          ob = b ^ mkey[8 * (3 - phase) +: 8];
          data = 1;
          phase = phase + 2'd1;
        end else begin
          ks = (len_kind == wsu_pkg::LEN_16) ? wsu_pkg::KEY_START_16 :
               (len_kind == wsu_pkg::LEN_64) ? wsu_pkg::KEY_START_64 : wsu_pkg::KEY_START_7;
          if (hdr_idx == 4'd0) begin
            opc = b[3:0];
            if ((b & wsu_pkg::FIN_MASK) == 8'h00) err = wsu_pkg::ST_NOT_FINAL;
            else if ((b & wsu_pkg::RSV_MASK) != 8'h00) err = wsu_pkg::ST_RESERVED;
          end else if (hdr_idx == 4'd1) begin
            if (!b[7]) err = wsu_pkg::ST_UNMASKED;
            else if (b[6:0] == wsu_pkg::LEN_ESC16) len_kind = wsu_pkg::LEN_16;
            else if (b[6:0] == wsu_pkg::LEN_ESC64) len_kind = wsu_pkg::LEN_64;
            else begin
              len_kind = wsu_pkg::LEN_7;
              len_acc = {57'd0, b[6:0]};
            end
          end else if (hdr_idx < ks) begin
            len_acc = {len_acc[55:0], b};
          end else begin
            mkey = {mkey[23:0], b};
            if (hdr_idx == ks + 4'd3) payload_on = 1;
          end
          if (hdr_idx != wsu_pkg::HDR_IDX_MAX) hdr_idx = hdr_idx + 4'd1;
        end
      end
      if (!last && !data) return;
      r.data = ob;
      r.has_data = data;
      r.eof = last;
      r.status = !last ? wsu_pkg::ST_OK : (err != wsu_pkg::ST_OK) ? err :
                 (!data ? wsu_pkg::ST_TRUNCATED : wsu_pkg::ST_OK);
      r.opcode = opc;
      r.length = len_acc;
      expected_beats.push_back(r);
      if (last) clear_parser();
    endfunction

    function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
      mismatches++;
    endfunction

    // compare one output beat against the oldest expectation
    function void check_out_beat(logic [79:0] d, logic user, logic lst);
      unmask_beat_t e;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected output beat, actual tdata %0h tuser %b tlast %b",
                 $time, d, user, lst);
        mismatches++;
        return;
      end
      e = expected_beats.pop_front();
      if (d[7:0] !== e.data) flag("out_byte", e.data, d[7:0]);
      if (user !== e.has_data) flag("has_data", e.has_data, user);
      if (lst !== e.eof) flag("end_of_frame", e.eof, lst);
      if (d[10:8] !== e.status) flag("status", e.status, d[10:8]);
      if (d[14:11] !== e.opcode) flag("frame_opcode", e.opcode, d[14:11]);
      if (d[78:15] !== e.length) flag("declared_length", e.length, d[78:15]);
      if (e.has_data) data_checked++;
      if (e.eof) ends_by_status[e.status]++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  unmask_scoreboard sb;
  logic [7:0] frame_q[$];
  int beats_sent;
  int packets_sent;
  int idle_cycles;
  bit drained_once;
  wire steady = (beats_sent >= 700) && (beats_sent < 1000);

  websocket_frame_unmasker DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #2 clk = ~clk;

  // receiver backpressure; none during the steady stretch
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : (steady || $urandom_range(99) >= 21);
  end

  // monitor both handshakes and run the watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) sb.take_rx_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_out_beat(m_tdata, m_tuser, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat moved for %0d cycles", $time, idle_cycles);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task send_beat(input logic [7:0] b, input bit last);
    if (!steady) begin
      while ($urandom_range(99) < 21) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task send_packet();
    foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
    packets_sent++;
  endtask

  function automatic void push_header(logic [7:0] b0, logic [1:0] kind,
                                      logic [63:0] dlen, logic [31:0] k);
    frame_q.push_back(b0);
    if (kind == wsu_pkg::LEN_16) begin
      frame_q.push_back({1'b1, wsu_pkg::LEN_ESC16});
      for (int i = 1; i >= 0; i--) frame_q.push_back(dlen[8 * i +: 8]);
    end else if (kind == wsu_pkg::LEN_64) begin
      frame_q.push_back({1'b1, wsu_pkg::LEN_ESC64});
      for (int i = 7; i >= 0; i--) frame_q.push_back(dlen[8 * i +: 8]);
    end else begin
      frame_q.push_back({1'b1, dlen[6:0]});
    end
    for (int i = 3; i >= 0; i--) frame_q.push_back(k[8 * i +: 8]);
  endfunction

  // mostly good frames with random content, the rest broken or noise
  task random_frame();
    logic [3:0] opcode;
    logic [1:0] kind;
    logic [63:0] dlen;
    int n;
    int pick;
    flaw_t flaw;
    opcode = $urandom_range(15);
    pick = $urandom_range(99);
    kind = (pick < 60) ? wsu_pkg::LEN_7 : (pick < 85) ? wsu_pkg::LEN_16 : wsu_pkg::LEN_64;
    if (kind == wsu_pkg::LEN_7) dlen = $urandom_range(125);
    else if (kind == wsu_pkg::LEN_16) dlen = $urandom_range(65535);
    else dlen = {$urandom, $urandom};
    n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    if (kind == wsu_pkg::LEN_7 && dlen >= 1 && dlen <= 40 && $urandom_range(1)) n = int'(dlen);
    push_header({1'b1, 3'b000, opcode}, kind, dlen, $urandom);
    if ($urandom_range(99) >= 85) begin
      flaw = flaw_t'($urandom_range(4));
      case (flaw)
        FLAW_NO_FIN:  frame_q[0][7] = 1'b0;
        FLAW_RSV:     frame_q[0][6:4] = $urandom_range(1, 7);
        FLAW_NO_MASK: frame_q[1][7] = 1'b0;
        FLAW_TRUNC: begin
          n = 0;
          frame_q = frame_q[0:$urandom_range(frame_q.size() - 1)];
        end
        FLAW_NOISE: begin
          frame_q.delete();
          n = $urandom_range(1, 20);
        end
      endcase
    end
    repeat (n) frame_q.push_back($urandom);
    send_packet();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    beats_sent = 0;
    packets_sent = 0;
    drained_once = 0;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: header errors, truncation at several points, extreme lengths and keys
    frame_q = '{8'h82};                                   // cut at the first byte
    send_packet();
    frame_q = '{8'h01, 8'hFF};                            // FIN clear, rest ignored
    send_packet();
    frame_q = '{8'hF0};                                   // reserved bits set
    send_packet();
    frame_q = '{8'h8A, 8'h05, 8'h00};                     // mask bit clear
    send_packet();
    frame_q = '{8'h81, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF};  // one payload byte
    send_packet();
    frame_q = '{8'h8F, 8'hFE, 8'h12, 8'h34};              // cut after the 16-bit length, before the key
    send_packet();
    push_header(8'h80, wsu_pkg::LEN_64, '1, 32'h0);       // widest length, zero key
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    send_packet();

    while (beats_sent < ITEM_TARGET) begin
      random_frame();
      // sender holds off once until the output side has caught up
      if (!drained_once && beats_sent >= 1200) begin
        drained_once = 1;
        s_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
      end
    end
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d packets; %0d unmasked payload bytes compared.",
             beats_sent, packets_sent, sb.data_checked);
    $display("Packet ends: ok %0d, not final %0d, reserved %0d, unmasked %0d, truncated %0d.",
             sb.ends_by_status[wsu_pkg::ST_OK], sb.ends_by_status[wsu_pkg::ST_NOT_FINAL],
             sb.ends_by_status[wsu_pkg::ST_RESERVED], sb.ends_by_status[wsu_pkg::ST_UNMASKED],
             sb.ends_by_status[wsu_pkg::ST_TRUNCATED]);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
